### rtl/set_assoc_cache_lru_lookup_unit_assert.svh
// Assertion macros for the cache lookup RTL.
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_UNIT_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SACL_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sacl assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SACL_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sacl assertion failed");

`endif

### rtl/sacl_pkg.sv
// Constants and types of the set-associative LRU cache lookup unit.
`timescale 1ns / 1ps
`default_nettype none

package sacl_pkg;

    localparam int MAX_SETS   = 64;
    localparam int MAX_WAYS   = 8;
    localparam int ADDR_WIDTH = 32;

    localparam int SET_W      = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int MAX_IB     = $clog2(MAX_SETS);
    localparam int WAY_W      = 3;
    localparam int AGE_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W     = $clog2(MAX_WAYS + 1);
    localparam int TAG_W      = ADDR_WIDTH;
    localparam int CNT_W      = 32;

    // Configuration port
    localparam int OFS_W      = 5;
    localparam int IB_W       = 3;
    localparam int WAYS_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

    // One set of the tag store: tags, valid bits and LRU ages of every way.
    typedef struct packed {
        logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
        logic [MAX_WAYS-1:0]            vld;
        logic [MAX_WAYS-1:0][AGE_W-1:0] age;
    } row_t;

endpackage

`default_nettype wire

### rtl/set_assoc_cache_lru_lookup_unit.sv
// Set-associative cache tag store with true LRU replacement, top level.
`timescale 1ns / 1ps
`default_nettype none
`include "set_assoc_cache_lru_lookup_unit_assert.svh"

// Usage
//   Input channel (in_valid/in_ready/address): one reference address per beat.
//   Output channel (out_valid/out_ready/...): one result beat per reference,
//   carrying hit, way, set_index and the saturating miss_total.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register 0 is
//   offset_bits, 1 is index_bits, 2 is ways_in_use; other indexes are ignored.
//   cfg_ready is always high; write only while no reference is in flight.
// Timing
//   A set row (all ways: tag, valid, age) lives in one synchronous RAM with a
//   registered read. The accept edge launches the row read; the lookup state
//   compares tags, picks the way, ages the set and, once the output register
//   is free, writes the row back while loading it; out_valid rises from that
//   load. A new reference waits for the row read-modify-write: in_ready is low
//   in the lookup state, also while it holds for a full output register.
// Stall
//   The result sits in the output register; the next reference is still
//   accepted, but its writeback holds until the output register is free.
// Reset
//   Clears the FSM, miss counter, config registers (0, 6, 8) and one row-valid
//   flop per set; an untouched set reads as all ways free, so no clearing pass.
module set_assoc_cache_lru_lookup_unit
    import sacl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // reference channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [ADDR_WIDTH-1:0] address,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       hit,
    output logic [WAY_W-1:0]           way,
    output logic [SET_W-1:0]           set_index,
    output logic [CNT_W-1:0]           miss_total,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOK = 1'b1;

    // control state
    logic                state_reg, state_next;
    logic                out_valid_reg;
    logic [MAX_SETS-1:0] rowv_reg;
    logic [CNT_W-1:0]    miss_cnt_reg;
    logic [OFS_W-1:0]    offset_bits_reg;
    logic [IB_W-1:0]     index_bits_reg;
    logic [WAYS_W-1:0]   ways_in_use_reg;

    // payload
    logic [TAG_W-1:0]    tag_reg;
    logic [SET_W-1:0]    set_reg;
    logic                hit_out_reg;
    logic [WAY_W-1:0]    way_out_reg;
    logic [SET_W-1:0]    set_out_reg;

    // tag store RAM
    row_t                mem [MAX_SETS];
    row_t                rdata_reg;
    logic                mem_re;
    logic                mem_we;
    row_t                wrow;

    // address split
    logic [IB_W-1:0]     ib_eff;
    logic [SET_W-1:0]    set_mask;
    logic [SET_W-1:0]    set_c;
    logic [5:0]          tshift;
    logic [TAG_W-1:0]    tag_c;
    logic [WCNT_W-1:0]   ways_eff;
    logic [AGE_W-1:0]    limit;

    // lookup results
    row_t                row_c;
    logic                out_load;
    logic                lk_hit;
    logic [WAY_W-1:0]    way_c;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign hit       = hit_out_reg;
    assign way       = way_out_reg;
    assign set_index = set_out_reg;
    assign miss_total = miss_cnt_reg;

    // Effective configuration: clamp index width and associativity.
    assign ib_eff   = (index_bits_reg > IB_W'(MAX_IB)) ? IB_W'(MAX_IB) : index_bits_reg;
    assign ways_eff = (ways_in_use_reg == '0) ? WCNT_W'(1) :
                      (ways_in_use_reg > WAYS_W'(MAX_WAYS)) ? WCNT_W'(MAX_WAYS) :
                      WCNT_W'(ways_in_use_reg);
    assign limit    = AGE_W'(ways_eff - WCNT_W'(1));

    // Set and tag of the incoming reference; shifts past the word give zero.
    assign set_mask = ~({SET_W{1'b1}} << ib_eff);
    assign set_c    = SET_W'(address >> offset_bits_reg) & set_mask;
    assign tshift   = 6'(offset_bits_reg) + 6'(ib_eff);
    assign tag_c    = address >> tshift;

    assign mem_re   = in_valid && in_ready;
    assign out_load = (state_reg == ST_LOOK) && (!out_valid_reg || out_ready);
    assign mem_we   = out_load;

    // A set never touched since reset reads as empty.
    assign row_c = rowv_reg[set_reg] ? rdata_reg : '0;

    // Compare, choose the way and age the set.
    always_comb
    begin
        logic [MAX_WAYS-1:0] lane_on;
        logic [MAX_WAYS-1:0] hit_vec;
        logic                free_c;
        logic [WAY_W-1:0]    hit_way;
        logic [WAY_W-1:0]    free_way;
        logic [WAY_W-1:0]    vic_way;
        logic [AGE_W-1:0]    best;
        logic                was_valid;
        logic [AGE_W-1:0]    ref_age;
        logic [AGE_W:0]      inc;

        lane_on  = '0;
        hit_vec  = '0;
        free_c   = 1'b0;
        hit_way  = '0;
        free_way = '0;
        vic_way  = '0;
        best     = '0;
        for (int k = 0; k < MAX_WAYS; k++)
        begin
            lane_on[k] = (WCNT_W'(k) < ways_eff);
            hit_vec[k] = lane_on[k] && row_c.vld[k] && (row_c.tag[k] == tag_reg);
        end
        // lowest hitting way, lowest free way, oldest way (lowest wins ties)
        for (int k = MAX_WAYS - 1; k >= 0; k--)
        begin
            if (hit_vec[k])
            begin
                hit_way = WAY_W'(k);
            end
            if (lane_on[k] && !row_c.vld[k])
            begin
                free_c   = 1'b1;
                free_way = WAY_W'(k);
            end
        end
        for (int k = 0; k < MAX_WAYS; k++)
        begin
            if (lane_on[k] && (k == 0 || row_c.age[k] > best))
            begin
                best    = row_c.age[k];
                vic_way = WAY_W'(k);
            end
        end

        lk_hit    = |hit_vec;
        way_c     = lk_hit ? hit_way : (free_c ? free_way : vic_way);
        was_valid = lk_hit || !free_c;
        ref_age   = row_c.age[way_c];

        wrow = row_c;
        for (int k = 0; k < MAX_WAYS; k++)
        begin
            inc = {1'b0, row_c.age[k]} + 1'b1;
            if (WAY_W'(k) == way_c)
            begin
                wrow.age[k] = '0;
                wrow.vld[k] = 1'b1;
                if (!lk_hit)
                begin
                    wrow.tag[k] = tag_reg;
                end
            end
            else if (lane_on[k] && row_c.vld[k])
            begin
                if (!was_valid || row_c.age[k] < ref_age)
                begin
                    wrow.age[k] = (inc > {1'b0, limit}) ? limit : inc[AGE_W-1:0];
                end
                else if (row_c.age[k] > limit)
                begin
                    wrow.age[k] = limit;
                end
            end
        end
    end

    // Row RAM: read on accept, write back on the lookup cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[set_reg] <= wrow;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[set_c];
        end
    end

    // FSM: idle -> lookup (hold while the output register is full) -> idle.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (mem_re)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            rowv_reg        <= '0;
            miss_cnt_reg    <= '0;
            offset_bits_reg <= '0;
            index_bits_reg  <= IB_W'(6);
            ways_in_use_reg <= WAYS_W'(8);
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg     <= 1'b1;
                rowv_reg[set_reg] <= 1'b1;
                if (!lk_hit && (miss_cnt_reg != '1))
                begin
                    miss_cnt_reg <= miss_cnt_reg + 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_OFFSET_BITS: offset_bits_reg <= cfg_data[OFS_W-1:0];
                    REG_INDEX_BITS:  index_bits_reg  <= cfg_data[IB_W-1:0];
                    REG_WAYS_IN_USE: ways_in_use_reg <= cfg_data[WAYS_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Latch the reference on accept; load the result beat on lookup.
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            tag_reg <= tag_c;
            set_reg <= set_c;
        end
        if (out_load)
        begin
            hit_out_reg <= lk_hit;
            way_out_reg <= way_c;
            set_out_reg <= set_reg;
        end
    end

    `SACL_ASSERT_NXT(a_accept_to_look, in_valid && in_ready, state_reg == ST_LOOK)
    `SACL_ASSERT_IMP(a_no_rw_overlap, mem_we, !mem_re)
    `SACL_ASSERT_IMP(a_way_in_use, out_load, WCNT_W'(way_c) < ways_eff)
    `SACL_ASSERT_NXT(a_hit_keeps_count, out_load && lk_hit, miss_cnt_reg == $past(miss_cnt_reg))
    `SACL_ASSERT_NXT(a_count_monotonic, 1'b1, miss_cnt_reg >= $past(miss_cnt_reg))

endmodule

`default_nettype wire
